// ----- rtl/tst_pkg.sv -----
// ---------------------------------------------------------------------------
// tst_pkg: shared types and constants of the timed setting table
// Request kinds, status codes, fixed field widths and pass control structs.
// ---------------------------------------------------------------------------
package tst_pkg;

  // fixed field widths of the request and result
  localparam int KIND_W    = 2;
  localparam int TICK_IN_W = 24;
  localparam int SET_W     = 5;
  localparam int SPAN_W    = 24;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_SET    = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd2;

  // progress of one pass over the table
  typedef struct packed {
    logic placed;   // set position reached
    logic dedup;    // still dropping entries equal to the new setting
    logic refused;  // set refused, table full
    logic ovf;      // an entry was shifted past the tick range
  } pass_flags_t;

  // what one entry of the pass turns into
  typedef struct packed {
    logic front;     // new set entry goes out ahead of this entry
    logic cand_vld;  // this entry is kept
    logic found_vld; // lookup: this entry is at or before the tick
  } xform_ctl_t;

endpackage

// ----- rtl/tst_xform.sv -----
// ---------------------------------------------------------------------------
// tst_xform: per-entry decision of the table pass
// Decides for one stored entry whether it is kept, moved, replaced or
// dropped, and whether a new set entry goes out in front of it.
// ---------------------------------------------------------------------------
module tst_xform
  import tst_pkg::*;
#(
  parameter int TICK_BITS = 24
) (
  input  kind_t                kind,
  input  logic [TICK_BITS-1:0] t,
  input  logic [SET_W-1:0]     s,
  input  logic [SPAN_W-1:0]    len,
  input  logic                 full,
  input  logic [TICK_BITS-1:0] et,
  input  logic [SET_W-1:0]     es,
  input  pass_flags_t          flags_in,
  output pass_flags_t          flags_out,
  output xform_ctl_t           ctl,
  output logic [TICK_BITS-1:0] cand_t
);

  localparam int SUM_W = ((TICK_BITS > SPAN_W) ? TICK_BITS : SPAN_W) + 1;
  localparam logic [SUM_W-1:0] TICK_MAX = SUM_W'((64'd1 << TICK_BITS) - 64'd1);

  logic [SUM_W-1:0] et_w;
  logic [SUM_W-1:0] t_w;
  logic [SUM_W-1:0] len_w;
  logic [SUM_W-1:0] end_w;
  logic [SUM_W-1:0] nsum;
  logic             ge_t;
  logic             active;

  // widened operands for shift arithmetic
  assign et_w   = SUM_W'(et);
  assign t_w    = SUM_W'(t);
  assign len_w  = SUM_W'(len);
  assign end_w  = t_w + len_w;
  assign nsum   = et_w + len_w;
  assign ge_t   = (et >= t);
  assign active = (t != '0) && (len != '0);

  // entry decision
  always_comb begin
    flags_out     = flags_in;
    ctl.front     = 1'b0;
    ctl.cand_vld  = 1'b1;
    ctl.found_vld = 1'b0;
    cand_t        = et;
    case (kind)
      KIND_LOOKUP: begin
        ctl.found_vld = (et <= t);
      end
      KIND_SET: begin
        if (!flags_in.placed && ge_t) begin
          flags_out.placed = 1'b1;
          if (et == t) begin
            // overwrite in place, old entry consumed
            ctl.front       = 1'b1;
            ctl.cand_vld    = 1'b0;
            flags_out.dedup = 1'b1;
          end else if (full) begin
            flags_out.refused = 1'b1;
          end else begin
            // new entry goes in ahead of this one
            ctl.front = 1'b1;
            if (es == s) begin
              ctl.cand_vld    = 1'b0;
              flags_out.dedup = 1'b1;
            end
          end
        end else if (flags_in.dedup) begin
          if (es == s) begin
            ctl.cand_vld = 1'b0;
          end else begin
            flags_out.dedup = 1'b0;
          end
        end
      end
      KIND_INSERT: begin
        if (active && ge_t) begin
          if (nsum > TICK_MAX) begin
            ctl.cand_vld  = 1'b0;
            flags_out.ovf = 1'b1;
          end else begin
            cand_t = TICK_BITS'(nsum);
          end
        end
      end
      KIND_REMOVE: begin
        if (active && ge_t) begin
          if (et_w < end_w) begin
            ctl.cand_vld = 1'b0;
          end else begin
            cand_t = TICK_BITS'(et_w - len_w);
          end
        end
      end
      default: begin
        ctl.cand_vld = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/timed_setting_table.sv -----
// ---------------------------------------------------------------------------
// timed_setting_table: time-sorted table of settings with set, lookup and shifts
// One request at a time: the next accept comes in the cycle after the result
// loads, and a result still waiting on out_tready holds the next one back. Cost
// set by one pass over the entry memory (one read, at most one write a cycle).
// Reset: rst_n synchronous, empties the table; entry memory is not cleared.
// ---------------------------------------------------------------------------
module timed_setting_table
  import tst_pkg::*;
#(
  parameter int ENTRIES   = 64,
  parameter int TICK_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [55:0]          in_tdata,  // tick[23:0], clef_index[28:24], span[52:29]
  input  logic [KIND_W-1:0]    in_tuser,  // kind[1:0]
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata  // setting[4:0], status[6:5], entry_count[13:7]
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int ENT_W = TICK_BITS + SET_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PASS  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  kind_t                 kind_r;
  logic [TICK_BITS-1:0]  t_r;
  logic [SET_W-1:0]      s_r;
  logic [SPAN_W-1:0]     len_r;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [CNT_W-1:0]      rd_idx_r;
  logic                  dv_r;
  logic [CNT_W-1:0]      wr_r, wr_nxt;
  pass_flags_t           flags_r, flags_nxt;
  logic                  carry_vld_r, carry_vld_nxt;
  logic [ENT_W-1:0]      carry_r, carry_nxt;
  logic [SET_W-1:0]      found_r;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  out_valid_r;
  logic [SET_W-1:0]      out_setting_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic [ENT_W-1:0]      mem [ENTRIES];
  logic [ENT_W-1:0]      rd_data_r;
  logic                  rd_en;
  logic                  mem_we;
  logic [ENT_W-1:0]      mem_wd;

  logic [TICK_BITS-1:0]  et;
  logic [SET_W-1:0]      es;
  logic [TICK_BITS-1:0]  cand_t;
  pass_flags_t           x_flags;
  xform_ctl_t            x_ctl;
  logic                  full;
  logic                  in_acc;
  logic                  out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (used_r == CNT_W'(ENTRIES));
  assign rd_en     = (state_r == ST_PASS) && (rd_idx_r < used_r);
  assign et        = rd_data_r[ENT_W-1:SET_W];
  assign es        = rd_data_r[SET_W-1:0];
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_r[IDX_W-1:0]] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  // per-entry decision
  tst_xform #(
    .TICK_BITS (TICK_BITS)
  ) u_xform (
    .kind      (kind_r),
    .t         (t_r),
    .s         (s_r),
    .len       (len_r),
    .full      (full),
    .et        (et),
    .es        (es),
    .flags_in  (flags_r),
    .flags_out (x_flags),
    .ctl       (x_ctl),
    .cand_t    (cand_t)
  );

  // write-back with one-entry carry for insertion
  always_comb begin
    mem_we        = 1'b0;
    mem_wd        = '0;
    carry_vld_nxt = carry_vld_r;
    carry_nxt     = carry_r;
    flags_nxt     = flags_r;
    if ((state_r == ST_PASS) && dv_r) begin
      flags_nxt = x_flags;
      if (x_ctl.front) begin
        mem_we = 1'b1;
        mem_wd = {t_r, s_r};
        if (x_ctl.cand_vld) begin
          carry_vld_nxt = 1'b1;
          carry_nxt     = {cand_t, es};
        end
      end else if (x_ctl.cand_vld) begin
        mem_we = 1'b1;
        if (carry_vld_r) begin
          mem_wd    = carry_r;
          carry_nxt = {cand_t, es};
        end else begin
          mem_wd = {cand_t, es};
        end
      end else if (carry_vld_r) begin
        mem_we        = 1'b1;
        mem_wd        = carry_r;
        carry_vld_nxt = 1'b0;
      end
    end else if (state_r == ST_FLUSH) begin
      if (carry_vld_r) begin
        mem_we        = 1'b1;
        mem_wd        = carry_r;
        carry_vld_nxt = 1'b0;
      end else if ((kind_r == KIND_SET) && !flags_r.placed && !full) begin
        mem_we = 1'b1;
        mem_wd = {t_r, s_r};
      end
    end
    wr_nxt = mem_we ? (wr_r + CNT_W'(1)) : wr_r;
  end

  // status of the finished pass
  always_comb begin
    status_nxt = STATUS_OK;
    case (kind_r)
      KIND_SET: begin
        if (flags_r.refused || (!flags_r.placed && full)) begin
          status_nxt = STATUS_FULL;
        end
      end
      KIND_INSERT: begin
        if (flags_r.ovf) begin
          status_nxt = STATUS_DROP;
        end
      end
      default: begin
        status_nxt = STATUS_OK;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        if (!rd_en && !dv_r) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        used_nxt  = wr_nxt;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      rd_idx_r    <= '0;
      dv_r        <= 1'b0;
      wr_r        <= '0;
      flags_r     <= '0;
      carry_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      if (in_acc) begin
        rd_idx_r    <= '0;
        dv_r        <= 1'b0;
        wr_r        <= '0;
        flags_r     <= '0;
        carry_vld_r <= 1'b0;
      end else begin
        rd_idx_r    <= rd_en ? (rd_idx_r + CNT_W'(1)) : rd_idx_r;
        dv_r        <= rd_en;
        wr_r        <= wr_nxt;
        flags_r     <= flags_nxt;
        carry_vld_r <= carry_vld_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request fields, carry data, lookup answer and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= kind_t'(in_tuser);
      t_r     <= TICK_BITS'(in_tdata[23:0]);
      s_r     <= in_tdata[28:24];
      len_r   <= in_tdata[52:29];
      found_r <= '0;
    end else if ((state_r == ST_PASS) && dv_r && x_ctl.found_vld) begin
      found_r <= es;
    end
    carry_r <= carry_nxt;
    if (state_r == ST_FLUSH) begin
      status_r <= status_nxt;
    end
    if (out_load) begin
      out_setting_r <= (kind_r == KIND_LOOKUP) ? found_r : '0;
      out_status_r  <= status_r;
      out_count_r   <= COUNT_W'(used_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_count_r, out_status_r, out_setting_r};

`ifndef SYNTHESIS
  // a write never lands on an entry not yet read
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_PASS) && mem_we) |-> (wr_r < rd_idx_r))
    else $error("pass write overtakes read");

  // entry count stays within the table
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(ENTRIES))
    else $error("entry count beyond table size");

  // carried entry only exists behind a placed set entry
  a_carry_set: assert property (@(posedge clk) disable iff (!rst_n)
    carry_vld_r |-> (flags_r.placed && (kind_r == KIND_SET)))
    else $error("carry without set insertion");

  // a lookup leaves the entry count unchanged
  a_lookup_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && (kind_r == KIND_LOOKUP)) |=> (used_r == $past(used_r)))
    else $error("lookup changed entry count");
`endif

endmodule
